// ----- rtl/core/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants and types for the stream pattern mask block.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_PATTERN_LIM = 8;
    localparam int CNT_W = $clog2(MAX_PATTERN_LIM + 1);

    localparam logic [7:0] STAR_BYTE = 8'h2A;

    localparam int ADDR_W = 4;
    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic             pop;
        logic             ins;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] len;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/stream_pattern_mask.sv -----
// ----------------------------------------------------------------------------
// stream_pattern_mask
// Masks every leftmost, non-overlapping occurrence of a configured byte
// pattern in a byte stream with asterisks of the same length.
//
//   Channel  Direction  Beat contents
//   s_       in         tdata[7:0] byte, tlast end of stream
//   m_       out        tdata[7:0] byte, tlast last beat of an input, tuser end
//   APB      in/out     0x0 pattern bytes (64 bits), 0x8 pattern length
//
// Each input beat enters a row of window cells, and the head byte leaves
// through the output register in the same cycle once the window holds a
// pattern length of bytes. A match or a stream end sends out one beat per
// cycle for the committed bytes while the output is not stalled and input is
// held off. Reset clears the window count and the output valid. A stall on the
// output holds the input side in the same cycle.
// ----------------------------------------------------------------------------
module stream_pattern_mask
    import spm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast,
    output logic              m_tuser,   // [0] stream_done
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [63:0]      pattern_bytes_reg;
    logic [3:0]       pattern_length_reg;
    logic [CNT_W-1:0] len;
    logic             cfg_wr;
    logic             reg_sel;
    cell_ctrl_t       cell_ctrl;
    logic [7:0]       cell_data [MAX_PATTERN];
    logic [7:0]       cell_view [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq_ok;
    logic             hit;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= 4'd1;
        end else if (cfg_wr) begin
            if (reg_sel == REG_PATTERN_BYTES) begin
                pattern_bytes_reg <= pwdata;
            end else begin
                pattern_length_reg <= pwdata[3:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_PATTERN_LENGTH) begin
            prdata = {60'd0, pattern_length_reg};
        end else begin
            prdata = pattern_bytes_reg;
        end
        if (pattern_length_reg == 4'd0) begin
            len = CNT_W'(1);
        end else if (pattern_length_reg > 4'(MAX_PATTERN)) begin
            len = CNT_W'(MAX_PATTERN);
        end else begin
            len = CNT_W'(pattern_length_reg);
        end
    end

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic [7:0] right_data;
        if (i == MAX_PATTERN - 1) begin : g_tail
            assign right_data = s_tdata;
        end else begin : g_mid
            assign right_data = cell_data[i+1];
        end
        spm_cell #(
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .in_byte    (s_tdata),
            .right_data (right_data),
            .pat_byte   (pattern_bytes_reg[8*i +: 8]),
            .data_o     (cell_data[i]),
            .view_o     (cell_view[i]),
            .eq_ok_o    (eq_ok[i])
        );
    end

    assign hit = &eq_ok;

    spm_ctrl #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .len       (len),
        .head_view (cell_view[0]),
        .head_data (cell_data[0]),
        .hit       (hit),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cell_ctrl (cell_ctrl)
    );

endmodule

// ----- rtl/core/spm_cell.sv -----
// ----------------------------------------------------------------------------
// spm_cell
// One window position: holds a pending byte, takes a new byte or its right
// neighbor's byte, and compares its window byte with its pattern byte.
// ----------------------------------------------------------------------------
module spm_cell
    import spm_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] in_byte,
    input  logic [7:0] right_data,
    input  logic [7:0] pat_byte,
    output logic [7:0] data_o,
    output logic [7:0] view_o,
    output logic       eq_ok_o
);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       load_here;
    logic       load_left;

    always_comb begin
        load_here = ctrl.ins && (ctrl.cnt == CNT_W'(IDX));
        load_left = ctrl.ins && (ctrl.cnt == CNT_W'(IDX + 1));
        view_o    = load_here ? in_byte : data_reg;
        eq_ok_o   = (view_o == pat_byte) || (CNT_W'(IDX) >= ctrl.len);
        if (ctrl.pop) begin
            data_next = load_left ? in_byte : right_data;
        end else begin
            data_next = view_o;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;

endmodule

// ----- rtl/core/spm_ctrl.sv -----
// ----------------------------------------------------------------------------
// spm_ctrl
// Window sequencer and output register: decides per cycle whether the window
// head leaves as itself or as an asterisk, and tracks the beats of a step.
// ----------------------------------------------------------------------------
module spm_ctrl
    import spm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] len,
    input  logic [7:0]       head_view,
    input  logic [7:0]       head_data,
    input  logic             hit,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser,
    output cell_ctrl_t       cell_ctrl
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] commit_reg, commit_next;
    logic             star_reg, star_next;
    logic             busy_reg, busy_next;
    logic             eos_reg, eos_next;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;
    logic             m_user_reg;

    logic             ostall;
    logic             ins;
    logic             burst;
    logic             decide;
    logic             emit;
    logic             more;
    logic             eos;
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] rem;
    logic [7:0]       emit_byte;

    always_comb begin
        ostall      = m_valid_reg && !m_tready;
        s_tready    = !busy_reg && !ostall;
        ins         = s_tvalid && s_tready;
        burst       = busy_reg && (commit_reg != '0);
        decide      = !ostall && !burst && (busy_reg || ins);
        c           = count_reg + CNT_W'(ins);
        eos         = busy_reg ? eos_reg : s_tlast;
        emit        = 1'b0;
        more        = busy_reg;
        rem         = count_reg;
        emit_byte   = head_view;
        commit_next = commit_reg;
        star_next   = star_reg;

        if (burst && !ostall) begin
            emit        = 1'b1;
            emit_byte   = star_reg ? STAR_BYTE : head_data;
            rem         = count_reg - CNT_W'(1);
            commit_next = commit_reg - CNT_W'(1);
            if (commit_reg == CNT_W'(1)) begin
                more = (rem >= len) || (eos_reg && (rem != '0));
            end else begin
                more = 1'b1;
            end
        end else if (decide) begin
            if (c >= len) begin
                emit      = 1'b1;
                emit_byte = hit ? STAR_BYTE : head_view;
                rem       = c - CNT_W'(1);
                if (hit && (len > CNT_W'(1))) begin
                    commit_next = len - CNT_W'(1);
                    star_next   = 1'b1;
                    more        = 1'b1;
                end else begin
                    more = (rem >= len) || (eos && (rem != '0));
                end
            end else if (eos) begin
                emit        = 1'b1;
                emit_byte   = head_view;
                rem         = c - CNT_W'(1);
                commit_next = rem;
                star_next   = 1'b0;
                more        = (rem != '0);
            end else begin
                rem  = c;
                more = 1'b0;
            end
        end

        count_next = rem;
        busy_next  = more;
        eos_next   = (burst && !ostall) || decide ? (more && eos) : eos_reg;

        cell_ctrl.pop = emit;
        cell_ctrl.ins = ins;
        cell_ctrl.cnt = count_reg;
        cell_ctrl.len = len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            commit_reg  <= '0;
            star_reg    <= 1'b0;
            busy_reg    <= 1'b0;
            eos_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            commit_reg <= commit_next;
            star_reg   <= star_next;
            busy_reg   <= busy_next;
            eos_reg    <= eos_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= emit_byte;
            m_last_reg <= !more;
            m_user_reg <= !more && eos;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_commit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_reg != '0) |-> busy_reg)
        else $error("committed beats outstanding while no step is active");

    a_commit_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_reg <= count_reg)
        else $error("more committed beats than pending bytes");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PATTERN))
        else $error("window count exceeds its depth");

    a_done_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !more && eos) |=> (count_reg == '0) && !busy_reg)
        else $error("window not empty after the final beat of a stream");

    a_no_emit_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ostall |-> !emit && !ins)
        else $error("beat produced while the output register is stalled");
`endif

endmodule
